>>> src/tpfa_pkg.sv
// Package for the two-pool first-fit allocator: sizes, codes and cell types.
// Used by the cell, arena and top-level modules.
`timescale 1ns / 1ps
package tpfa_pkg;
  localparam int BIG_BYTES     = 4096;
  localparam int SMALL_BYTES   = 1024;
  localparam int HEADER_BYTES  = 16;
  localparam int BIG_ENTRIES   = 256;
  localparam int SMALL_ENTRIES = 64;

  // One offset/size width covers both arenas; upper bits stay zero in the small one.
  localparam int OW = 17;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_MEM    = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_NOT_BLOCK = 3'd3;
  localparam logic [2:0] ST_DBL_FREE  = 3'd4;

  typedef enum logic [1:0] {OP_NONE, OP_INSERT, OP_REMOVE, OP_UPDATE} op_e_t;

  typedef struct packed {
    logic          used;
    logic          fr;
    logic [OW-1:0] start;
    logic [OW-1:0] size;
  } entry_t;

  // Command broadcast from the arena controller to every cell.
  typedef struct packed {
    op_e_t         op;
    logic [12:0]   idx;      // target entry
    logic          fr;       // new free mark for the target
    logic [OW-1:0] size;     // new size for the target
    logic [OW-1:0] nstart;   // start of an inserted entry (at idx+1)
    logic [OW-1:0] nsize;
  } cmd_t;
endpackage

>>> src/tpfa_cell.sv
// One table entry of an arena. It shifts toward its neighbors on insert or remove.
// Depends on tpfa_pkg.
`timescale 1ns / 1ps
module tpfa_cell import tpfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [12:0] my_idx,
  input  entry_t      rst_val,
  input  cmd_t        cmd,
  input  entry_t      from_lo,   // entry below
  input  entry_t      from_hi,   // entry above
  output entry_t      q
);
  entry_t q_r, q_nxt;
  assign q = q_r;

  always_comb begin
    q_nxt = q_r;
    case (cmd.op)
      OP_UPDATE: begin
        if (my_idx == cmd.idx) begin
          q_nxt.fr = cmd.fr;
          q_nxt.size = cmd.size;
        end
      end
      OP_INSERT: begin
        if (my_idx == cmd.idx) begin
          q_nxt.fr = cmd.fr;
          q_nxt.size = cmd.size;
        end else if (my_idx == cmd.idx + 13'd1) begin
          q_nxt = '{used: 1'b1, fr: 1'b1, start: cmd.nstart, size: cmd.nsize};
        end else if (my_idx > cmd.idx + 13'd1) begin
          q_nxt = from_lo;
        end
      end
      OP_REMOVE: begin
        if (my_idx >= cmd.idx) q_nxt = from_hi;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_r <= rst_val;
    else q_r <= q_nxt;
  end
endmodule

>>> src/tpfa_arena.sv
// Both arenas as rows of cells, each with the combinational search that picks a
// first fit or a matching payload. Depends on tpfa_pkg and tpfa_cell.
`timescale 1ns / 1ps
module tpfa_arena import tpfa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t [1:0]         cmd,       // row 0 small arena, row 1 big arena
  input  logic [OW-1:0]      req,
  input  logic [OW-1:0]      off,
  output logic [1:0]         fit_hit,
  output logic [1:0][12:0]   fit_idx,
  output entry_t [1:0]       fit_e,
  output logic [1:0]         full,
  output logic [1:0]         pay_hit,
  output logic [1:0][12:0]   pay_idx,
  output entry_t [1:0]       pay_e,
  output entry_t [1:0]       pay_prev,
  output entry_t [1:0]       pay_next
);
  entry_t blank;
  assign blank = '0;

  for (genvar r = 0; r < 2; r++) begin : g_row
    localparam int N      = (r == 1) ? BIG_ENTRIES : SMALL_ENTRIES;
    localparam int NBYTES = (r == 1) ? BIG_BYTES : SMALL_BYTES;
    entry_t e [N];
    logic f_hit, p_hit;
    logic [12:0] f_idx, p_idx;
    entry_t f_e, p_e, p_prev, p_next;

    for (genvar g = 0; g < N; g++) begin : g_cell
      entry_t rv;
      assign rv = (g == 0) ? entry_t'{used: 1'b1, fr: 1'b1, start: OW'(0),
                                      size: OW'(NBYTES - HEADER_BYTES)} : entry_t'('0);
      tpfa_cell u_cell (
        .clk(clk), .rst_n(rst_n), .my_idx(13'(g)), .rst_val(rv), .cmd(cmd[r]),
        .from_lo((g == 0) ? blank : e[(g == 0) ? 0 : g - 1]),
        .from_hi((g == N - 1) ? blank : e[(g == N - 1) ? g : g + 1]),
        .q(e[g])
      );
    end

    assign full[r] = e[N-1].used;

    // Priority scans: lowest matching entry wins.
    always_comb begin
      f_hit = 1'b0; f_idx = '0; f_e = '0;
      p_hit = 1'b0; p_idx = '0; p_e = '0; p_prev = '0; p_next = '0;
      for (int i = N - 1; i >= 0; i--) begin
        if (e[i].used && e[i].fr && e[i].size >= req) begin
          f_hit = 1'b1; f_idx = 13'(i); f_e = e[i];
        end
        if (e[i].used && e[i].start + OW'(HEADER_BYTES) == off) begin
          p_hit = 1'b1; p_idx = 13'(i); p_e = e[i];
          p_prev = (i > 0) ? e[(i > 0) ? i - 1 : 0] : '0;
          p_next = (i < N - 1) ? e[(i < N - 1) ? i + 1 : i] : '0;
        end
      end
    end

    assign fit_hit[r]  = f_hit;
    assign fit_idx[r]  = f_idx;
    assign fit_e[r]    = f_e;
    assign pay_hit[r]  = p_hit;
    assign pay_idx[r]  = p_idx;
    assign pay_e[r]    = p_e;
    assign pay_prev[r] = p_prev;
    assign pay_next[r] = p_next;
  end
endmodule

>>> src/two_pool_first_fit_allocator.sv
// Two-pool first-fit allocator. After an item is accepted, an allocate searches
// each arena it tries in turn (S_ALLOC); a free does a check-and-update (S_FREE)
// and then one remove (S_MERGE2) per merged neighbor, before S_OUT.
// One item is in work at a time; the result waits in an output register, so a
// new item is accepted only after the result has been taken.
// Synchronous reset restores one free block per arena and threshold 256.
`timescale 1ns / 1ps
module two_pool_first_fit_allocator import tpfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_size[15:0], free_region, free_offset[12:0]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[2:0], result_region, result_offset[12:0]
);
  typedef enum logic [2:0] {S_IDLE, S_ALLOC, S_FREE, S_MERGE2, S_OUT} state_t;
  state_t st_r;
  logic [12:0] thr_r;
  logic reg_r, second_r;
  logic [OW-1:0] req_r, off_r;
  logic [2:0] status_r;
  logic res_reg_r;
  logic [12:0] res_off_r;
  logic [12:0] m_idx_r;
  logic m_two_r;

  cmd_t cmd;
  cmd_t [1:0] cmds;
  logic [1:0] fh, fl, ph;
  logic [1:0][12:0] fi, pi;
  entry_t [1:0] fe, pe, pp, pn;

  tpfa_arena u_arena (
    .clk, .rst_n, .cmd(cmds), .req(req_r), .off(off_r),
    .fit_hit(fh), .fit_idx(fi), .fit_e(fe), .full(fl),
    .pay_hit(ph), .pay_idx(pi), .pay_e(pe), .pay_prev(pp),
    .pay_next(pn));

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = {7'd0, res_off_r, res_reg_r, status_r};

  // Merge plan for a free: which neighbors fold into the freed block.
  logic mrg_prev, mrg_next;
  assign mrg_prev = pi[reg_r] != 13'd0 && pp[reg_r].fr;
  assign mrg_next = pn[reg_r].used && pn[reg_r].fr;

  // Combinational command for the arena selected by reg_r.
  logic [OW-1:0] sum;
  always_comb begin
    cmd = '0;
    sum = '0;
    case (st_r)
      S_ALLOC: if (fh[reg_r]) begin
        cmd.idx = fi[reg_r];
        cmd.fr = 1'b0;
        if (fe[reg_r].size >= req_r + OW'(HEADER_BYTES) && !fl[reg_r]) begin
          cmd.op = OP_INSERT;
          cmd.size = req_r;
          cmd.nstart = fe[reg_r].start + OW'(HEADER_BYTES) + req_r;
          cmd.nsize = fe[reg_r].size - OW'(HEADER_BYTES) - req_r;
        end else begin
          cmd.op = OP_UPDATE;
          cmd.size = fe[reg_r].size;
        end
      end
      S_FREE: if (off_r <= OW'(reg_r ? BIG_BYTES : SMALL_BYTES) && ph[reg_r]
                  && !pe[reg_r].fr) begin
        cmd.fr = 1'b1;
        if (mrg_prev) begin
          // The previous block grows over this one, and over the next one too
          // when that is free; the removes follow.
          sum = pp[reg_r].size + OW'(HEADER_BYTES) + pe[reg_r].size;
          if (mrg_next) sum = sum + OW'(HEADER_BYTES) + pn[reg_r].size;
          cmd.op = OP_UPDATE;
          cmd.idx = pi[reg_r] - 13'd1;
          cmd.size = sum;
        end else if (mrg_next) begin
          cmd.op = OP_UPDATE;
          cmd.idx = pi[reg_r];
          cmd.size = pe[reg_r].size + OW'(HEADER_BYTES) + pn[reg_r].size;
        end else begin
          cmd.op = OP_UPDATE;
          cmd.idx = pi[reg_r];
          cmd.size = pe[reg_r].size;
        end
      end
      S_MERGE2: begin
        cmd.op = OP_REMOVE;
        cmd.idx = m_idx_r;
      end
      default: cmd = '0;
    endcase
  end
  assign cmds[0] = reg_r ? cmd_t'('0) : cmd;
  assign cmds[1] = reg_r ? cmd : cmd_t'('0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      thr_r <= 13'd256;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      case (st_r)
        S_IDLE: if (in_tvalid) begin
          req_r <= OW'(in_tdata[15:0]);
          off_r <= OW'(in_tdata[29:17]);
          second_r <= 1'b0;
          res_reg_r <= 1'b0; res_off_r <= '0; status_r <= ST_OK;
          if (in_tuser) begin
            reg_r <= in_tdata[16];
            st_r <= S_FREE;
          end else begin
            reg_r <= !(in_tdata[15:0] < 16'(thr_r));
            st_r <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          if (fh[reg_r]) begin
            res_reg_r <= reg_r;
            res_off_r <= 13'(fe[reg_r].start + OW'(HEADER_BYTES));
            st_r <= S_OUT;
          end else if (!second_r) begin
            second_r <= 1'b1;
            reg_r <= !reg_r;
          end else begin
            status_r <= ST_NO_MEM;
            st_r <= S_OUT;
          end
        end
        S_FREE: begin
          st_r <= S_OUT;
          if (off_r > OW'(reg_r ? BIG_BYTES : SMALL_BYTES)) status_r <= ST_OUTSIDE;
          else if (!ph[reg_r]) status_r <= ST_NOT_BLOCK;
          else if (pe[reg_r].fr) status_r <= ST_DBL_FREE;
          else if (mrg_prev) begin
            m_idx_r <= pi[reg_r];
            m_two_r <= mrg_next;
            st_r <= S_MERGE2;
          end else if (mrg_next) begin
            m_idx_r <= pi[reg_r] + 13'd1;
            m_two_r <= 1'b0;
            st_r <= S_MERGE2;
          end
        end
        S_MERGE2: begin
          // Merge into the previous block: the first remove drops the freed entry,
          // the second a merged next entry at that index. Else one drops the next.
          if (m_two_r) begin
            m_two_r <= 1'b0;
            st_r <= S_MERGE2;
          end else st_r <= S_OUT;
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ALLOC && fh[reg_r]) |=> status_r == ST_OK)
    else $error("grant with bad status");
endmodule

>>> test/tb_two_pool_first_fit_allocator.sv
// Testbench for the two-pool first-fit allocator: directed and random
// allocate/free items checked against a behavioral model of both arenas.
// Depends on tpfa_pkg and the two_pool_first_fit_allocator RTL.
`timescale 1ns / 1ps

typedef struct {
  logic [2:0]  status;
  logic        region;
  logic [12:0] offset;
} alloc_result_t;

class alloc_scoreboard;
  int unsigned threshold;
  int unsigned blk_start[2][$];
  int unsigned blk_size[2][$];
  bit          blk_free[2][$];
  alloc_result_t pending[$];
  int errors;

  function void clear_arenas();
    threshold = 256;
    foreach (blk_start[r]) begin
      blk_start[r].delete(); blk_size[r].delete(); blk_free[r].delete();
    end
    blk_start[0].push_back(0); blk_size[0].push_back(tpfa_pkg::SMALL_BYTES - 16);
    blk_free[0].push_back(1);
    blk_start[1].push_back(0); blk_size[1].push_back(tpfa_pkg::BIG_BYTES - 16);
    blk_free[1].push_back(1);
  endfunction

  function int arena_cap(int r);
    return r ? tpfa_pkg::BIG_ENTRIES : tpfa_pkg::SMALL_ENTRIES;
  endfunction

  // First-fit search; returns the payload offset or -1.
  function int first_fit(int r, int unsigned req);
    int hb;
    hb = tpfa_pkg::HEADER_BYTES;
    for (int i = 0; i < blk_start[r].size(); i++) begin
      if (blk_size[r][i] < req || !blk_free[r][i]) continue;
      if (blk_size[r][i] >= req + hb && blk_start[r].size() < arena_cap(r)) begin
        blk_start[r].insert(i + 1, blk_start[r][i] + hb + req);
        blk_size[r].insert(i + 1, blk_size[r][i] - hb - req);
        blk_free[r].insert(i + 1, 1);
        blk_size[r][i] = req;
      end
      blk_free[r][i] = 0;
      return blk_start[r][i] + hb;
    end
    return -1;
  endfunction

  function logic [2:0] release_block(int r, int unsigned off);
    int i, hb;
    hb = tpfa_pkg::HEADER_BYTES;
    if (off > (r ? tpfa_pkg::BIG_BYTES : tpfa_pkg::SMALL_BYTES)) return tpfa_pkg::ST_OUTSIDE;
    for (i = 0; i < blk_start[r].size(); i++)
      if (blk_start[r][i] + hb == off) break;
    if (i >= blk_start[r].size()) return tpfa_pkg::ST_NOT_BLOCK;
    if (blk_free[r][i]) return tpfa_pkg::ST_DBL_FREE;
    blk_free[r][i] = 1;
    if (i > 0 && blk_free[r][i-1]) begin
      blk_size[r][i-1] += hb + blk_size[r][i];
      blk_start[r].delete(i); blk_size[r].delete(i); blk_free[r].delete(i);
      i--;
    end
    if (i + 1 < blk_start[r].size() && blk_free[r][i+1]) begin
      blk_size[r][i] += hb + blk_size[r][i+1];
      blk_start[r].delete(i+1); blk_size[r].delete(i+1); blk_free[r].delete(i+1);
    end
    return tpfa_pkg::ST_OK;
  endfunction

  function void note_request(bit is_free, int unsigned req, bit reg_sel, int unsigned off);
    alloc_result_t e;
    int p, pref;
    e = '{tpfa_pkg::ST_OK, 1'b0, 13'd0};
    if (!is_free) begin
      pref = (req < threshold) ? 0 : 1;
      p = first_fit(pref, req);
      if (p >= 0) begin
        e.region = 1'(pref); e.offset = 13'(p);
      end else begin
        p = first_fit(pref ^ 1, req);
        if (p >= 0) begin
          e.region = 1'(pref ^ 1); e.offset = 13'(p);
        end else e.status = tpfa_pkg::ST_NO_MEM;
      end
    end else e.status = release_block(reg_sel, off);
    pending.push_back(e);
  endfunction

  function void check_result(logic [23:0] d);
    alloc_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, d);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (d[2:0] !== e.status || d[3] !== e.region || d[16:4] !== e.offset) begin
      $display("%0t: mismatch expected status %0d region %0d offset %0d, actual %0d %0d %0d",
               $time, e.status, e.region, e.offset, d[2:0], d[3], d[16:4]);
      errors++;
    end
  endfunction

  // Random payload offset of a currently held block, else a junk offset.
  function int unsigned pick_live(output bit r);
    int unsigned cand_o[$];
    bit cand_r[$];
    int k;
    for (int a = 0; a < 2; a++)
      foreach (blk_start[a][i])
        if (!blk_free[a][i]) begin
          cand_o.push_back(blk_start[a][i] + 16); cand_r.push_back(1'(a));
        end
    if (cand_o.size() == 0) begin
      r = 1'($urandom_range(1)); return $urandom_range(4096);
    end
    k = $urandom_range(cand_o.size() - 1);
    r = cand_r[k];
    return cand_o[k];
  endfunction
endclass

module tb_two_pool_first_fit_allocator;
  import tpfa_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [12:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  alloc_scoreboard sb;
  int  cycles;
  bit  no_idle;
  bit  hold_off;

  two_pool_first_fit_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (out_tvalid && out_tready && rst_n) sb.check_result(out_tdata);
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);
  end

  task automatic send_item(bit is_free, int unsigned req, bit reg_sel, int unsigned off);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_free;
    in_tdata  <= {3'b0, off[12:0], reg_sel, req[15:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(is_free, req & 32'hffff, reg_sel, off & 32'h1fff);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(int unsigned v);
    cfg_we <= 1'b1;
    cfg_wdata <= v[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.threshold = v & 13'h1fff;
    @(posedge clk);
  endtask

  task automatic random_item();
    bit r;
    int unsigned off;
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) begin
      if ($urandom_range(9) == 0) send_item(0, $urandom_range(65535), 0, $urandom);
      else send_item(0, $urandom_range(300), 1'($urandom_range(1)), $urandom);
    end else if (sel < 85) begin
      off = sb.pick_live(r);
      send_item(1, $urandom, r, off);
    end else begin
      off = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(4096);
      send_item(1, $urandom, 1'($urandom_range(1)), off);
    end
  endtask

  initial begin
    bit r;
    int unsigned off;
    sb = new();
    sb.clear_arenas();
    rst_n = 0; cfg_we = 0; cfg_wdata = 0; in_tvalid = 0; in_tdata = 0; in_tuser = 0;
    out_tready = 0; no_idle = 0; hold_off = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero size, exact fit, remainder of zero, oversize, bad frees.
    send_item(0, 0, 0, 0);
    send_item(0, 255, 0, 0);
    send_item(0, 256, 0, 0);
    send_item(0, 65535, 1, 8191);
    send_item(1, 0, 0, 16);
    send_item(1, 0, 0, 16);
    send_item(1, 0, 0, 1025);
    send_item(1, 0, 0, 1024);
    send_item(1, 0, 1, 4096);
    send_item(1, 0, 1, 4097);
    send_item(1, 0, 1, 8191);
    send_item(1, 0, 1, 17);
    send_item(0, 4064 - 256 - 16, 1, 0);
    send_item(0, 1000, 0, 0);
    send_item(0, 5000, 0, 0);
    off = sb.pick_live(r); send_item(1, 65535, r, off);
    off = sb.pick_live(r); send_item(1, 0, r, off);
    drain();

    write_threshold(0);
    for (int i = 0; i < 150; i++) random_item();
    drain();
    write_threshold(8191);
    no_idle = 1;
    for (int i = 0; i < 150; i++) random_item();
    no_idle = 0;
    drain();

    // Long receiver stall while items keep coming.
    hold_off = 1;
    fork
      begin repeat (300) @(posedge clk); hold_off = 0; end
      for (int i = 0; i < 20; i++) random_item();
    join
    drain();

    write_threshold(4096);
    for (int i = 0; i < 150; i++) random_item();
    drain();
    write_threshold($urandom_range(4096));
    for (int i = 0; i < 60; i++) send_item(0, $urandom_range(4), 0, 0);
    for (int i = 0; i < 100; i++) random_item();
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
